### hdl/sbfd_pkg.sv
// ============================================================================
// Stuffed byte frame deframer package
// Shared constants, controller states and the command and status bundles
// that join the controller and the datapath.
// ============================================================================
package sbfd_pkg;

  // Frame store depth in bytes.
  localparam int FRAME_BYTES = 27;

  // Width of the fill count, which must hold FRAME_BYTES itself.
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  // Width of an address into the frame store.
  localparam int IDX_W = $clog2(FRAME_BYTES);

  // Fixed widths of the stream fields.
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int FIELD_W = 5;
  localparam int TMO_W   = 16;

  localparam int IN_TDATA_W  = BYTE_W + TIME_W;
  localparam int OUT_FIELD_W = BYTE_W + 2 * FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Byte codes of the framing.
  localparam logic [BYTE_W-1:0] DELIM_BYTE       = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE         = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR          = 8'h20;
  localparam logic [BYTE_W-1:0] HEADER_LEN_BYTE  = BYTE_W'(FRAME_BYTES - 2);
  localparam logic [BYTE_W-1:0] HEADER_TYPE_BYTE = 8'h00;

  // Timeout register value after reset, in microseconds.
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(3000 + 500);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_READ,
    ST_LOAD
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // take the accepted request into the holding registers
    logic proc;     // apply the held request to the frame state
    logic rd_en;    // read the store at the current emit index
    logic load;     // move the read byte into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit_req;  // the held request closes a non-empty frame
    logic last;      // the current emit index is the final byte
    logic out_free;  // the output register can take a byte this cycle
  } sts_t;

endpackage

### hdl/stuffed_byte_frame_deframer_core.sv
// ============================================================================
// Stuffed byte frame deframer
// Removes byte stuffing from a received serial stream and emits each
// completed frame one byte per request with its length and a header check.
// ============================================================================
// Each input request carries one raw received byte and its microsecond
// arrival time. The byte 0x7E delimits frames, and 0x7D makes the next
// stored byte XOR 0x20. Up to 27 de-stuffed bytes are kept; once the store
// is full, further data bytes are dropped until the next delimiter. A
// partial frame whose age since the opening delimiter (a signed 32-bit
// difference, so the time may wrap) exceeds frame_timeout_us is discarded
// before the new byte is handled. On a delimiter that closes a non-empty
// frame the block sends one output request per stored byte, in order, with
// tlast on the final one. An input request passes through intake and then
// the update of the frame state. On a closing delimiter each stored byte is
// read from the frame store into a read data register and then, once the
// output register is free, moved into it; no input request is taken until
// the final byte has moved. tready on the input side returns as soon as the
// last byte sits in the output register, so the next request can be accepted
// while that byte still waits to be taken. The timeout register may only be
// written while the block is idle.
module stuffed_byte_frame_deframer_core (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration: frame_timeout_us.
  input  logic                                cfg_wr_en,
  input  logic [sbfd_pkg::TMO_W-1:0]          cfg_wr_data,
  // Received bytes.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] rx_byte, [39:8] now_us.
  input  logic [sbfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Frame bytes.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] frame_byte, [12:8] byte_index, [17:13] frame_length, rest zero.
  output logic [sbfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // last_byte.
  output logic                                m_axis_tlast,
  // [0] header_ok.
  output logic                                m_axis_tuser
);

  sbfd_pkg::cmd_t cmd;
  sbfd_pkg::sts_t sts;

  // The controller sequences intake, update and emission; it drives the
  // input tready directly and the datapath only through the command bundle.
  sbfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the frame store, the timeout check and the output
  // register that parts the two stream sides.
  sbfd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_tdata    (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_tdata   (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .out_user    (m_axis_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

### hdl/sbfd_ctrl.sv
// ============================================================================
// Deframer controller
// Sequences request intake, frame state update and the byte-by-byte
// emission of a completed frame.
// ============================================================================
module sbfd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbfd_pkg::sts_t sts,
  output sbfd_pkg::cmd_t cmd
);

  sbfd_pkg::state_t state;
  sbfd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sbfd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sbfd_pkg::ST_PROC;
        end
      end
      sbfd_pkg::ST_PROC: begin
        if (sts.emit_req) begin
          state_next = sbfd_pkg::ST_READ;
        end else begin
          state_next = sbfd_pkg::ST_IDLE;
        end
      end
      sbfd_pkg::ST_READ: begin
        state_next = sbfd_pkg::ST_LOAD;
      end
      sbfd_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          state_next = sts.last ? sbfd_pkg::ST_IDLE : sbfd_pkg::ST_READ;
        end
      end
      default: begin
        state_next = sbfd_pkg::ST_IDLE;
      end
    endcase
  end

  // No request is taken while reset is held.
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.proc    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.load    = 1'b0;
    case (state)
      sbfd_pkg::ST_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      sbfd_pkg::ST_PROC: begin
        cmd.proc = 1'b1;
      end
      sbfd_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      sbfd_pkg::ST_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hdl/sbfd_datapath.sv
// ============================================================================
// Deframer datapath
// Holds the request, the frame store and counters, the timeout check and
// the output register.
// ============================================================================
module sbfd_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [sbfd_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [sbfd_pkg::TMO_W-1:0]            cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sbfd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_last,
  output logic                                  out_user,
  input  sbfd_pkg::cmd_t                        cmd,
  output sbfd_pkg::sts_t                        sts
);

  // Held request.
  logic [sbfd_pkg::BYTE_W-1:0] hold_byte;
  logic [sbfd_pkg::TIME_W-1:0] hold_now;

  // Frame state.
  logic [sbfd_pkg::BYTE_W-1:0] store [sbfd_pkg::FRAME_BYTES];
  logic [sbfd_pkg::CNT_W-1:0]  fill;
  logic                        esc_armed;
  logic [sbfd_pkg::TIME_W-1:0] start_time;
  logic [sbfd_pkg::TMO_W-1:0]  timeout_us;
  logic                        hdr0_ok;
  logic                        hdr1_ok;

  // Emission state.
  logic [sbfd_pkg::CNT_W-1:0]  frame_len;
  logic                        frame_ok;
  logic [sbfd_pkg::CNT_W-1:0]  emit_idx;
  logic [sbfd_pkg::BYTE_W-1:0] rd_data;

  // Output register payload.
  logic [sbfd_pkg::BYTE_W-1:0]  out_byte;
  logic [sbfd_pkg::FIELD_W-1:0] out_idx;
  logic [sbfd_pkg::FIELD_W-1:0] out_len;

  logic [sbfd_pkg::TIME_W-1:0] age;
  logic                        timed_out;
  logic [sbfd_pkg::CNT_W-1:0]  fill_eff;
  logic                        is_delim;
  logic                        is_esc;
  logic                        is_full;
  logic [sbfd_pkg::BYTE_W-1:0] data_byte;
  logic                        do_write;
  logic                        emit_last;

  // Signed wraparound age against the timeout.
  assign age       = hold_now - start_time;
  assign timed_out = !age[sbfd_pkg::TIME_W-1]
                     && (age[sbfd_pkg::TIME_W-2:0] > (sbfd_pkg::TIME_W-1)'(timeout_us));
  assign fill_eff  = ((fill != '0) && timed_out) ? '0 : fill;

  assign is_delim  = (hold_byte == sbfd_pkg::DELIM_BYTE);
  assign is_esc    = (hold_byte == sbfd_pkg::ESC_BYTE);
  assign is_full   = (fill_eff >= sbfd_pkg::CNT_W'(sbfd_pkg::FRAME_BYTES));
  assign data_byte = esc_armed ? (hold_byte ^ sbfd_pkg::ESC_XOR) : hold_byte;
  assign do_write  = cmd.proc && !is_delim && !is_esc && !is_full;
  assign emit_last = ((emit_idx + 1'b1) == frame_len);

  assign sts.emit_req = is_delim && (fill_eff != '0);
  assign sts.last     = emit_last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_byte <= in_tdata[sbfd_pkg::BYTE_W-1:0];
      hold_now  <= in_tdata[sbfd_pkg::IN_TDATA_W-1:sbfd_pkg::BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= sbfd_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_us <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      esc_armed  <= 1'b0;
      start_time <= '0;
    end else if (cmd.proc) begin
      if (is_delim) begin
        fill       <= '0;
        esc_armed  <= 1'b0;
        start_time <= hold_now;
      end else if (is_esc) begin
        fill      <= fill_eff;
        esc_armed <= 1'b1;
      end else if (is_full) begin
        fill <= fill_eff;
      end else begin
        fill      <= fill_eff + 1'b1;
        esc_armed <= 1'b0;
      end
    end
  end

  // Frame store and the header bytes, tracked as they are written.
  always_ff @(posedge clk) begin
    if (do_write) begin
      store[fill_eff[sbfd_pkg::IDX_W-1:0]] <= data_byte;
      if (fill_eff == sbfd_pkg::CNT_W'(0)) begin
        hdr0_ok <= (data_byte == sbfd_pkg::HEADER_LEN_BYTE);
      end
      if (fill_eff == sbfd_pkg::CNT_W'(1)) begin
        hdr1_ok <= (data_byte == sbfd_pkg::HEADER_TYPE_BYTE);
      end
    end
    if (cmd.rd_en) begin
      rd_data <= store[emit_idx[sbfd_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.proc && is_delim) begin
      frame_len <= fill_eff;
      frame_ok  <= (fill_eff == sbfd_pkg::CNT_W'(sbfd_pkg::FRAME_BYTES)) && hdr0_ok && hdr1_ok;
      emit_idx  <= '0;
    end else if (cmd.load) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte <= rd_data;
      out_idx  <= sbfd_pkg::FIELD_W'(emit_idx);
      out_len  <= sbfd_pkg::FIELD_W'(frame_len);
      out_last <= emit_last;
      out_user <= frame_ok;
    end
  end

  assign out_tdata = sbfd_pkg::OUT_TDATA_W'({out_len, out_idx, out_byte});

  // The fill count never passes the store depth.
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= sbfd_pkg::CNT_W'(sbfd_pkg::FRAME_BYTES))
    else $error("fill count beyond frame store depth");

  // A byte is only loaded from inside the frame being emitted.
  a_load_in_frame : assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (emit_idx < frame_len))
    else $error("emit index outside the frame");

  // Nothing is written into the store while a frame is being emitted.
  a_no_write_in_emit : assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || cmd.load) |-> !do_write)
    else $error("store written during emission");

  // A processed delimiter with a non-empty frame starts a read next cycle.
  a_emit_start : assert property (@(posedge clk) disable iff (rst)
    (cmd.proc && sts.emit_req) |=> cmd.rd_en)
    else $error("frame emission did not start");

endmodule

### sim/stuffed_byte_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Stuffed byte frame deframer testbench
// Drives stuffed serial bytes with arrival times into the deframer. A
// scoreboard tracks the frame state and checks every emitted frame byte.
// ============================================================================

// One emitted frame byte with all of its side fields.
typedef struct packed {
  logic [7:0] frame_byte;
  logic [4:0] byte_index;
  logic       last_byte;
  logic [4:0] frame_length;
  logic       header_ok;
} frame_byte_t;

// Keeps its own copy of the deframer state and the timeout register. Each
// accepted request updates that copy, and each closed frame is queued as the
// bytes the block has to send.
class frame_scoreboard;
  logic [7:0]  frame_copy [sbfd_pkg::FRAME_BYTES];
  int unsigned fill;
  bit          escape_pending;
  logic [31:0] frame_open_us;
  logic [15:0] timeout_us;
  frame_byte_t expected_bytes [$];
  int          errors;

  function new();
    foreach (frame_copy[i]) frame_copy[i] = 8'h00;
    fill           = 0;
    escape_pending = 1'b0;
    frame_open_us  = 32'd0;
    timeout_us     = sbfd_pkg::TIMEOUT_RESET;
    errors         = 0;
  endfunction

  function void set_timeout(logic [15:0] value);
    timeout_us = value;
  endfunction

  function void note_request(logic [7:0] rx, logic [31:0] now);
    int          age;
    bit          hdr;
    frame_byte_t fb;
    // The age is a signed difference, so the time may wrap or step back.
    age = $signed(now - frame_open_us);
    if (fill > 0 && age > int'(timeout_us)) fill = 0;

    if (rx == sbfd_pkg::DELIM_BYTE) begin
      hdr = fill == sbfd_pkg::FRAME_BYTES &&
            frame_copy[0] == sbfd_pkg::HEADER_LEN_BYTE &&
            frame_copy[1] == sbfd_pkg::HEADER_TYPE_BYTE;
      for (int i = 0; i < fill; i++) begin
        fb.frame_byte   = frame_copy[i];
        fb.byte_index   = 5'(i);
        fb.last_byte    = (i + 1 == fill);
        fb.frame_length = 5'(fill);
        fb.header_ok    = hdr;
        expected_bytes.push_back(fb);
      end
      fill           = 0;
      frame_open_us  = now;
      escape_pending = 1'b0;
    end else if (rx == sbfd_pkg::ESC_BYTE) begin
      escape_pending = 1'b1;
    end else if (fill < sbfd_pkg::FRAME_BYTES) begin
      // A full store drops the byte and leaves a pending escape armed.
      if (escape_pending) begin
        rx             = rx ^ sbfd_pkg::ESC_XOR;
        escape_pending = 1'b0;
      end
      frame_copy[fill] = rx;
      fill++;
    end
  endfunction

  function void check_result(logic [7:0] fbyte, logic [4:0] idx, logic lastb,
                             logic [4:0] len, logic hok);
    frame_byte_t exp;
    if (expected_bytes.size() == 0) begin
      $error("unexpected frame byte %0h at index %0d", fbyte, idx);
      errors++;
      return;
    end
    exp = expected_bytes.pop_front();
    if (fbyte !== exp.frame_byte) begin
      $error("frame_byte expected %0h actual %0h", exp.frame_byte, fbyte);
      errors++;
    end
    if (idx !== exp.byte_index) begin
      $error("byte_index expected %0d actual %0d", exp.byte_index, idx);
      errors++;
    end
    if (lastb !== exp.last_byte) begin
      $error("last_byte expected %0b actual %0b", exp.last_byte, lastb);
      errors++;
    end
    if (len !== exp.frame_length) begin
      $error("frame_length expected %0d actual %0d", exp.frame_length, len);
      errors++;
    end
    if (hok !== exp.header_ok) begin
      $error("header_ok expected %0b actual %0b", exp.header_ok, hok);
      errors++;
    end
  endfunction
endclass

module stuffed_byte_frame_deframer_core_tb;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [sbfd_pkg::TMO_W-1:0]       cfg_wr_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [sbfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [sbfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;
  logic                             m_axis_tuser;

  frame_scoreboard sb;

  // Time base of the generated stream, in microseconds.
  logic [31:0] clock_us = 32'd0;
  int          requests_sent = 0;
  int          sender_calm = 0;

  // Sink side bookkeeping, touched only by the sink process.
  int results_seen = 0;
  int stall_left = 0;
  int calm_left = 0;
  bit long_hold_done = 1'b0;
  int sink_roll;

  stuffed_byte_frame_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Draws an idle stretch: mostly a short one and now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Advances the stream time. Most steps are small, as on a real link; a few
  // jump far ahead, step back, land anywhere or sit just below the wrap.
  // A step limit of zero keeps the time almost still, which lets frames
  // survive a zero timeout now and then.
  function automatic logic [31:0] next_time(int step_max);
    int r;
    r = $urandom_range(0, 999);
    if (r < 4) clock_us = $urandom;
    else if (r < 8) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 300);
    else if (r < 16) clock_us += $urandom_range(2000, 70000);
    else if (r < 24) clock_us -= $urandom_range(1, 400);
    else if (step_max == 0) clock_us += 32'($urandom_range(0, 29) == 0);
    else clock_us += $urandom_range(0, step_max);
    return clock_us;
  endfunction

  // Offers one byte and holds it until the block takes it. tvalid stays high
  // into the next request unless a gap is drawn, so it is never lowered and
  // raised in the same step.
  task automatic send_item(input logic [7:0] rx, input logic [31:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, rx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(rx, now);
    requests_sent++;
    if (sender_calm > 0) begin
      sender_calm--;
    end else if ($urandom_range(0, 99) < 2) begin
      sender_calm = $urandom_range(20, 60);
    end else if ($urandom_range(0, 99) < 45) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  // Sends one frame closed by a delimiter, or a short burst of noise. Frames
  // are mostly well formed: some carry a valid header at full length, some
  // overrun the store, some are tiny. Payload bytes that collide with the
  // framing codes are escaped, and a few others are escaped anyway.
  task automatic send_frame(input int step_max);
    int         kind;
    int         len;
    int         r;
    logic [7:0] v;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(0, 9);
        v = (r == 0) ? sbfd_pkg::DELIM_BYTE :
            (r == 1) ? sbfd_pkg::ESC_BYTE : 8'($urandom_range(0, 255));
        send_item(v, next_time(step_max));
      end
      return;
    end
    if (kind < 40) len = sbfd_pkg::FRAME_BYTES;
    else if (kind < 52)
      len = $urandom_range(sbfd_pkg::FRAME_BYTES + 1, sbfd_pkg::FRAME_BYTES + 6);
    else if (kind < 62) len = $urandom_range(1, 3);
    else len = $urandom_range(1, sbfd_pkg::FRAME_BYTES);
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom_range(0, 255));
      // Full-length frames usually carry the header, sometimes a near miss.
      if (kind < 40 && i == 0)
        v = ($urandom_range(0, 9) == 0) ? sbfd_pkg::HEADER_LEN_BYTE + 8'd1
                                        : sbfd_pkg::HEADER_LEN_BYTE;
      if (kind < 40 && i == 1)
        v = ($urandom_range(0, 9) == 0) ? sbfd_pkg::HEADER_TYPE_BYTE + 8'd1
                                        : sbfd_pkg::HEADER_TYPE_BYTE;
      if (v == sbfd_pkg::DELIM_BYTE || v == sbfd_pkg::ESC_BYTE ||
          $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 29) == 0) send_item(sbfd_pkg::ESC_BYTE, next_time(step_max));
        send_item(sbfd_pkg::ESC_BYTE, next_time(step_max));
        v = v ^ sbfd_pkg::ESC_XOR;
      end
      send_item(v, next_time(step_max));
    end
    send_item(sbfd_pkg::DELIM_BYTE, next_time(step_max));
    if ($urandom_range(0, 9) == 0) send_item(sbfd_pkg::DELIM_BYTE, next_time(step_max));
  endtask

  // Waits until every queued frame byte is out and the last request has
  // settled, so the register is written only while the block is idle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic configure_timeout(input logic [15:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_timeout(value);
  endtask

  task automatic run_random(input int count, input int step_max);
    int target;
    target = requests_sent + count;
    while (requests_sent < target) send_frame(step_max);
  endtask

  // Sink: checks each accepted frame byte and then picks tready for the next
  // cycle. It stalls at random, has calm stretches with tready held high,
  // and once holds off for a long stretch so that the block fills up and
  // stops taking requests while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tlast,
                        m_axis_tdata[17:13], m_axis_tuser);
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        stall_left     = 400;
        m_axis_tready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        m_axis_tready <= 1'b1;
      end else begin
        sink_roll = $urandom_range(0, 99);
        if (sink_roll < 2) calm_left = $urandom_range(50, 200);
        if (sink_roll >= 2 && sink_roll < 30) begin
          stall_left = gap_len() - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the timeout value left by reset.
    // Data ahead of the first delimiter is kept and timed from zero.
    send_item(8'h55, 32'd5);
    send_item(sbfd_pkg::DELIM_BYTE, 32'd10);
    // Two delimiters in a row close an empty frame and send nothing.
    send_item(sbfd_pkg::DELIM_BYTE, 32'd20);
    // Extreme data values, an escaped delimiter, and a repeated escape
    // in front of an escaped escape code.
    send_item(8'h00, 32'd30);
    send_item(8'hFF, 32'd40);
    send_item(sbfd_pkg::ESC_BYTE, 32'd50);
    send_item(sbfd_pkg::DELIM_BYTE ^ sbfd_pkg::ESC_XOR, 32'd60);
    send_item(sbfd_pkg::ESC_BYTE, 32'd70);
    send_item(sbfd_pkg::ESC_BYTE, 32'd80);
    send_item(sbfd_pkg::ESC_BYTE ^ sbfd_pkg::ESC_XOR, 32'd90);
    // An age equal to the timeout is still in time.
    send_item(sbfd_pkg::DELIM_BYTE, 32'd3520);
    // One microsecond past the timeout drops the partial frame first,
    // then the new byte starts over; the closing delimiter then finds it
    // timed out too and sends nothing.
    send_item(8'h41, 32'd3600);
    send_item(8'h42, 32'd7021);
    send_item(sbfd_pkg::DELIM_BYTE, 32'd7022);
    // A timeout keeps a pending escape armed.
    send_item(8'h11, 32'd7030);
    send_item(sbfd_pkg::ESC_BYTE, 32'd7040);
    send_item(8'h44, 32'd11000);
    send_item(sbfd_pkg::DELIM_BYTE, 32'd11001);
    // Time stepping back gives a negative age, which never times out.
    send_item(8'h01, 32'd10001);
    send_item(sbfd_pkg::DELIM_BYTE, 32'hFFFF_FFF0);
    // A frame across the wrap of the time counter.
    send_item(8'hA5, 32'h0000_0100);
    send_item(sbfd_pkg::DELIM_BYTE, 32'h0000_0200);
    clock_us = 32'h0000_0200;

    // Random part over several timeout settings, extremes included.
    configure_timeout(16'hFFFF);
    run_random(120, 150);
    configure_timeout(16'h0000);
    run_random(100, 0);
    configure_timeout(16'($urandom_range(300, 3000)));
    run_random(130, 200);

    wait_idle();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("stuffed_byte_frame_deframer_core_tb OK");
    end else begin
      $display("stuffed_byte_frame_deframer_core_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("stuffed_byte_frame_deframer_core_tb NOT OK");
    $finish;
  end

endmodule

### files.f
hdl/sbfd_pkg.sv
hdl/sbfd_ctrl.sv
hdl/sbfd_datapath.sv
hdl/stuffed_byte_frame_deframer_core.sv
sim/stuffed_byte_frame_deframer_core_tb.sv
